### rtl/clock_offset_estimator_unit_assert.svh
// Assertion macros for the clock offset estimator.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef CLOCK_OFFSET_ESTIMATOR_UNIT_ASSERT_SVH
`define CLOCK_OFFSET_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define COE_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("coe: same-cycle check failed");

// next-cycle implication
`define COE_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("coe: next-cycle check failed");

`endif

### rtl/coe_pkg.sv
// Shared constants, command/status types and saturation helpers
// for the clock offset estimator. No dependencies.
package coe_pkg;

  localparam int TS_W      = 63;
  localparam int VAL_W     = 64;
  localparam int APPLIED_W = 48;
  localparam int CNT_OUT_W = 32;
  localparam int RATE_W    = 10;
  localparam int CFG_W     = 17;
  localparam int OUT_FRAC  = 16;

  localparam int DEF_WEIGHT_FRAC_BITS = 16;
  localparam int DEF_COUNT_BITS       = 32;
  localparam int DEF_SYNC_AFTER       = 3;

  localparam logic [CFG_W-1:0] WEIGHT_RESET = 17'd6554;
  localparam int RATE_SCALE = 1000;
  localparam int RATE_STEPS = RATE_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic capture;
    logic diff;
    logic raw;
    logic mul_step;
    logic load_b;
    logic fin;
    logic load_out;
  } coe_cmd_t;

  typedef struct packed {
    logic op_timeout;
    logic seed;
    logic div_done;
  } coe_sts_t;

  function automatic logic [VAL_W-1:0] sat65(input logic [VAL_W:0] v);
    logic [VAL_W-1:0] r;
    if (v[VAL_W] == v[VAL_W-1]) r = v[VAL_W-1:0];
    else if (v[VAL_W]) r = VAL_MIN;
    else r = VAL_MAX;
    return r;
  endfunction

  // v * 2^OUT_FRAC, saturated
  function automatic logic [VAL_W-1:0] scale_sat(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    logic [OUT_FRAC:0] top;
    top = v[VAL_W-1:VAL_W-1-OUT_FRAC];
    if ((&top) || !(|top)) r = {v[VAL_W-1-OUT_FRAC:0], {OUT_FRAC{1'b0}}};
    else if (v[VAL_W-1]) r = VAL_MIN;
    else r = VAL_MAX;
    return r;
  endfunction

endpackage

### rtl/coe_ifs.sv
// Channel interfaces: input item, result item and weight register write.
// Depends on coe_pkg for field widths.
interface coe_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [coe_pkg::TS_W-1:0]  local_send_time;
  logic [coe_pkg::TS_W-1:0]  master_recv_time;
  logic [coe_pkg::TS_W-1:0]  master_send_time;
  logic [coe_pkg::TS_W-1:0]  local_recv_time;
  modport source (output valid, operation, local_send_time, master_recv_time,
                  master_send_time, local_recv_time, input ready);
  modport sink (input valid, operation, local_send_time, master_recv_time,
                master_send_time, local_recv_time, output ready);
endinterface

interface coe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [coe_pkg::VAL_W-1:0]     raw_offset;
  logic signed [coe_pkg::VAL_W-1:0]     round_trip;
  logic signed [coe_pkg::APPLIED_W-1:0] applied_offset;
  logic [coe_pkg::CNT_OUT_W-1:0]        success_total;
  logic [coe_pkg::CNT_OUT_W-1:0]        failure_total;
  logic [coe_pkg::RATE_W-1:0]           success_rate_tenths;
  logic                                in_sync;
  logic                                sync_changed;
  modport source (output valid, raw_offset, round_trip, applied_offset, success_total,
                  failure_total, success_rate_tenths, in_sync, sync_changed,
                  input ready);
  modport sink (input valid, raw_offset, round_trip, applied_offset, success_total,
                failure_total, success_rate_tenths, in_sync, sync_changed,
                output ready);
endinterface

interface coe_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [coe_pkg::CFG_W-1:0]  smoothing_weight;
  modport source (output valid, smoothing_weight, input ready);
  modport sink (input valid, smoothing_weight, output ready);
endinterface

### rtl/coe_ctrl.sv
// Sequencer for the clock offset estimator: steps the datapath through
// offset, EMA multiply and result load. Depends on coe_pkg.
module coe_ctrl #(
  parameter int WEIGHT_FRAC_BITS = coe_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output coe_pkg::coe_cmd_t cmd,
  input  coe_pkg::coe_sts_t sts
);

  localparam int STEP_W = $clog2(WEIGHT_FRAC_BITS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WEIGHT_FRAC_BITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_RAW    = 3'd2;
  localparam logic [2:0] S_MULA   = 3'd3;
  localparam logic [2:0] S_LOADB  = 3'd4;
  localparam logic [2:0] S_MULB   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_RAW;
      end
      S_RAW: begin
        cmd.raw  = 1'b1;
        step_nxt = '0;
        if (sts.op_timeout || sts.seed) state_nxt = S_FINISH;
        else state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.mul_step = 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = S_LOADB;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LOADB: begin
        cmd.load_b = 1'b1;
        state_nxt  = S_MULB;
      end
      S_MULB: begin
        cmd.mul_step = 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.div_done && out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/coe_dpath.sv
// Datapath of the clock offset estimator: timestamp differences, offset,
// bit-serial EMA multiply-accumulate, restoring rate divider, counters.
// Depends on coe_pkg.
module coe_dpath #(
  parameter int WEIGHT_FRAC_BITS = coe_pkg::DEF_WEIGHT_FRAC_BITS,
  parameter int COUNT_BITS       = coe_pkg::DEF_COUNT_BITS,
  parameter int SYNC_AFTER       = coe_pkg::DEF_SYNC_AFTER
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  coe_pkg::coe_cmd_t                    cmd,
  output coe_pkg::coe_sts_t                    sts,
  input  logic                                 cfg_valid,
  input  logic [coe_pkg::CFG_W-1:0]            cfg_weight,
  input  logic                                 operation,
  input  logic [coe_pkg::TS_W-1:0]             local_send_time,
  input  logic [coe_pkg::TS_W-1:0]             master_recv_time,
  input  logic [coe_pkg::TS_W-1:0]             master_send_time,
  input  logic [coe_pkg::TS_W-1:0]             local_recv_time,
  output logic signed [coe_pkg::VAL_W-1:0]     raw_offset,
  output logic signed [coe_pkg::VAL_W-1:0]     round_trip,
  output logic signed [coe_pkg::APPLIED_W-1:0] applied_offset,
  output logic [coe_pkg::CNT_OUT_W-1:0]        success_total,
  output logic [coe_pkg::CNT_OUT_W-1:0]        failure_total,
  output logic [coe_pkg::RATE_W-1:0]           success_rate_tenths,
  output logic                                 in_sync,
  output logic                                 sync_changed
);

  localparam int VW    = coe_pkg::VAL_W;
  localparam int F     = WEIGHT_FRAC_BITS;
  localparam int ACC_W = VW + 1 + F;
  localparam int CW    = (coe_pkg::CFG_W > F + 1) ? coe_pkg::CFG_W : F + 1;
  localparam int DW    = COUNT_BITS + coe_pkg::RATE_W;
  localparam int DC_W  = $clog2(coe_pkg::RATE_STEPS + 1);
  localparam int RW    = coe_pkg::RATE_W;

  localparam logic [F:0]         WONE  = {1'b1, {F{1'b0}}};
  localparam logic [ACC_W-1:0]   ROUND = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] SYNC_CNT = COUNT_BITS'(SYNC_AFTER);
  localparam logic [DW-1:0]      SCALE = DW'(coe_pkg::RATE_SCALE);
  localparam logic [DC_W-1:0]    DIV_STEPS = DC_W'(coe_pkg::RATE_STEPS);
  localparam logic [VW-1:0]      APPLY_BIAS = VW'({coe_pkg::OUT_FRAC{1'b1}});

  // architectural state
  logic [VW-1:0]         smooth_r;
  logic [COUNT_BITS-1:0] succ_r, fail_r;
  logic                  sync_r;
  logic [coe_pkg::CFG_W-1:0] weight_r;
  logic [DC_W-1:0]       div_cnt_r;

  // working registers
  logic                  op_r, changed_r;
  logic [VW-1:0]         rtt_r, d21_r, d32_r, raw_r, oq_r;
  logic [VW:0]           diff_r;
  logic signed [ACC_W-1:0] acc_r, mcand_r;
  logic [F:0]            mplier_r;
  logic [DW-1:0]         rem_r, dv_r;
  logic [RW-1:0]         q_r;

  logic signed [VW:0]    diff_s, diff_half;
  logic [VW:0]           raw_sum;
  logic [VW-1:0]         raw_nxt, oq_nxt;
  logic [CW-1:0]         w_ext, w_cl;
  logic [F:0]            w_c;
  logic signed [ACC_W-1:0] acc_sh;
  logic [DW:0]           trial;
  logic [COUNT_BITS:0]   total;
  logic                  newflag;
  logic [VW-1:0]         apply_sum;

  assign diff_s    = diff_r;
  assign diff_half = diff_s >>> 1;
  // arithmetic halving floors: a negative odd difference is corrected up by one
  assign raw_sum   = {d21_r[VW-1], d21_r} + diff_half
                     + {{VW{1'b0}}, diff_r[VW] & diff_r[0]};
  assign raw_nxt   = coe_pkg::sat65(raw_sum);
  assign oq_nxt    = coe_pkg::scale_sat(raw_nxt);

  assign w_ext = CW'(weight_r);
  assign w_cl  = (w_ext > CW'(WONE)) ? CW'(WONE) : w_ext;
  assign w_c   = w_cl[F:0];

  assign acc_sh  = acc_r >>> F;
  assign trial   = {1'b0, rem_r} - {1'b0, dv_r};
  assign total   = {1'b0, succ_r} + {1'b0, fail_r};
  assign newflag = (succ_r >= SYNC_CNT);
  assign apply_sum = smooth_r + (smooth_r[VW-1] ? APPLY_BIAS : '0);

  assign sts.op_timeout = op_r;
  assign sts.seed       = (succ_r == CNT_ONE);
  assign sts.div_done   = (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r  <= '0;
      succ_r    <= '0;
      fail_r    <= '0;
      sync_r    <= 1'b0;
      weight_r  <= coe_pkg::WEIGHT_RESET;
      div_cnt_r <= '0;
    end else begin
      if (cfg_valid) weight_r <= cfg_weight;
      if (cmd.diff) begin
        if (op_r) begin
          if (fail_r != CNT_MAX) fail_r <= fail_r + 1'b1;
        end else begin
          if (succ_r != CNT_MAX) succ_r <= succ_r + 1'b1;
        end
      end
      if (cmd.raw) begin
        div_cnt_r <= DIV_STEPS;
        if (!op_r) begin
          sync_r <= newflag;
          if (sts.seed) smooth_r <= oq_nxt;
        end
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (cmd.fin) smooth_r <= coe_pkg::sat65(acc_sh[VW:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= operation;
      rtt_r <= {1'b0, local_recv_time} - {1'b0, local_send_time};
      d21_r <= {1'b0, master_recv_time} - {1'b0, local_send_time};
      d32_r <= {1'b0, master_send_time} - {1'b0, master_recv_time};
    end
    if (cmd.diff) diff_r <= {rtt_r[VW-1], rtt_r} - {d32_r[VW-1], d32_r};
    if (cmd.raw) begin
      raw_r     <= raw_nxt;
      oq_r      <= oq_nxt;
      changed_r <= !op_r && (newflag != sync_r);
      mcand_r   <= {{(ACC_W-VW){smooth_r[VW-1]}}, smooth_r};
      mplier_r  <= WONE - w_c;
      acc_r     <= ROUND;
      rem_r     <= DW'(succ_r) * SCALE;
      dv_r      <= {total, {(RW-1){1'b0}}};
      q_r       <= '0;
    end else if (div_cnt_r != '0) begin
      if (!trial[DW]) rem_r <= trial[DW-1:0];
      q_r  <= {q_r[RW-2:0], !trial[DW]};
      dv_r <= dv_r >> 1;
    end
    if (cmd.mul_step) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.load_b) begin
      mcand_r  <= {{(ACC_W-VW){oq_r[VW-1]}}, oq_r};
      mplier_r <= w_c;
    end
    if (cmd.load_out) begin
      raw_offset          <= op_r ? '0 : raw_r;
      round_trip          <= op_r ? '0 : rtt_r;
      applied_offset      <= apply_sum[VW-1:coe_pkg::OUT_FRAC];
      success_total       <= coe_pkg::CNT_OUT_W'(succ_r);
      failure_total       <= coe_pkg::CNT_OUT_W'(fail_r);
      success_rate_tenths <= q_r;
      in_sync             <= sync_r;
      sync_changed        <= changed_r;
    end
  end

endmodule

### rtl/clock_offset_estimator_unit.sv
// Top level of the clock offset estimator: controller plus datapath.
// Depends on coe_pkg, coe_ifs, coe_ctrl, coe_dpath and the assertion header.
//
// One item at a time. For a completed exchange the time from acceptance to
// result is set by the bit-serial EMA multiply-accumulate, which runs one
// pass over the weight bits for the held value and one for the new offset.
// A timeout, and the first success that seeds the average, wait instead on
// the 10-step restoring divider for the success rate. The result waits in
// an output register, so the next item is taken while it is still unread;
// a new result is held back only while the previous one is still pending.
// The weight register may be written at any time the block is idle.
`include "clock_offset_estimator_unit_assert.svh"

module clock_offset_estimator_unit #(
  parameter int WEIGHT_FRAC_BITS = coe_pkg::DEF_WEIGHT_FRAC_BITS,
  parameter int COUNT_BITS       = coe_pkg::DEF_COUNT_BITS,
  parameter int SYNC_AFTER       = coe_pkg::DEF_SYNC_AFTER
) (
  input logic      clk,
  input logic      rst_n,
  coe_in_if.sink   in_chan,
  coe_out_if.source out_chan,
  coe_cfg_if.sink  cfg_chan
);

  localparam logic [coe_pkg::CNT_OUT_W-1:0] SYNC_TOTAL = coe_pkg::CNT_OUT_W'(SYNC_AFTER);

  coe_pkg::coe_cmd_t cmd;
  coe_pkg::coe_sts_t sts;
  logic              sync_expected;

  assign cfg_chan.ready = 1'b1;
  assign sync_expected  = (out_chan.success_total >= SYNC_TOTAL);

  coe_ctrl #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  coe_dpath #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .COUNT_BITS      (COUNT_BITS),
    .SYNC_AFTER      (SYNC_AFTER)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_chan.valid),
    .cfg_weight          (cfg_chan.smoothing_weight),
    .operation           (in_chan.operation),
    .local_send_time     (in_chan.local_send_time),
    .master_recv_time    (in_chan.master_recv_time),
    .master_send_time    (in_chan.master_send_time),
    .local_recv_time     (in_chan.local_recv_time),
    .raw_offset          (out_chan.raw_offset),
    .round_trip          (out_chan.round_trip),
    .applied_offset      (out_chan.applied_offset),
    .success_total       (out_chan.success_total),
    .failure_total       (out_chan.failure_total),
    .success_rate_tenths (out_chan.success_rate_tenths),
    .in_sync             (out_chan.in_sync),
    .sync_changed        (out_chan.sync_changed)
  );

  `COE_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  `COE_ASSERT_NOW(a_rate_range, out_chan.valid, out_chan.success_rate_tenths <= 10'd1000)
  `COE_ASSERT_NOW(a_sync_matches_count, out_chan.valid, out_chan.in_sync == sync_expected)
  `COE_ASSERT_NOW(a_change_rises_only, out_chan.valid && out_chan.sync_changed, out_chan.in_sync)

endmodule
